@@ design/segint_pkg.sv @@
package segint_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIV_WIDTH   = 8;
    localparam int OUT_WIDTH   = 24;
    localparam int ADDR_WIDTH  = 3;

    // coordinate difference, pair product, cross term
    localparam int DW   = COORD_WIDTH + 1;
    localparam int PW   = 2 * DW;
    localparam int EW   = PW + 1;
    // crossing numerator, scaled denominator
    localparam int NXW  = EW + DW + 1;
    localparam int UDW  = EW + DIV_WIDTH + 1;
    localparam int DDW  = UDW + 1;
    localparam int NW   = NXW + 6;
    // quotient bits: |result| <= 16 * 2^(COORD_WIDTH-1)
    localparam int QW   = COORD_WIDTH + 4;
    localparam int RW   = DDW + QW;

    localparam logic [0:0] REG_X_DIVISOR = 1'b0;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_SLOPED,
        MODE_VERT
    } mode_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] ax0;
        logic signed [COORD_WIDTH-1:0] ay0;
        logic signed [COORD_WIDTH-1:0] ax1;
        logic signed [COORD_WIDTH-1:0] ay1;
        logic signed [COORD_WIDTH-1:0] bx0;
        logic signed [COORD_WIDTH-1:0] by0;
        logic signed [COORD_WIDTH-1:0] bx1;
        logic signed [COORD_WIDTH-1:0] by1;
    } seg_in_t;

    typedef struct packed {
        logic                        hit;
        logic signed [OUT_WIDTH-1:0] cross_x;
        logic signed [OUT_WIDTH-1:0] cross_y;
    } seg_out_t;

endpackage

@@ design/segint_rdiv.sv @@
module segint_rdiv import segint_pkg::*; (
    input  logic           aclk,
    input  logic [QW-1:0]  adv,
    input  logic [NW-1:0]  num,
    input  logic [DDW-1:0] den,
    output logic [QW-1:0]  quo
);

    // restoring divider, one quotient bit per stage, MSB first
    logic [RW-1:0]  r_reg    [QW];
    logic [DDW-1:0] d_reg    [QW];
    logic [QW-1:0]  q_reg    [QW];
    logic [RW-1:0]  r_prev   [QW];
    logic [DDW-1:0] d_prev   [QW];
    logic [QW-1:0]  q_prev   [QW];
    logic [RW-1:0]  r_next   [QW];
    logic [QW-1:0]  q_next   [QW];

    always_comb begin
        r_prev[0] = RW'(num);
        d_prev[0] = den;
        q_prev[0] = '0;
        for (int j = 1; j < QW; j++) begin
            r_prev[j] = r_reg[j-1];
            d_prev[j] = d_reg[j-1];
            q_prev[j] = q_reg[j-1];
        end
    end

    always_comb begin
        for (int j = 0; j < QW; j++) begin
            if (r_prev[j] >= (RW'(d_prev[j]) << (QW - 1 - j))) begin
                r_next[j] = r_prev[j] - (RW'(d_prev[j]) << (QW - 1 - j));
                q_next[j] = q_prev[j] | (QW'(1) << (QW - 1 - j));
            end else begin
                r_next[j] = r_prev[j];
                q_next[j] = q_prev[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < QW; j++) begin
            if (adv[j]) begin
                r_reg[j] <= r_next[j];
                d_reg[j] <= d_prev[j];
                q_reg[j] <= q_next[j];
            end
        end
    end

    assign quo = q_reg[QW-1];

endmodule

@@ design/segment_intersection.sv @@
// channel   dir  handshake          beat
// s_        in   s_valid/s_ready    seg_in_t: two segments, Q12.4 endpoints
// m_        out  m_valid/m_ready    seg_out_t: hit, cross_x, cross_y (Q16.8)
// apb       in   psel/penable       x_divisor at word 0
//
// One beat accepted per cycle while s_ready is high; cross_x and cross_y come
// from the bit-per-stage rounding dividers for x and y.
// Synchronous active-low reset clears valids; x_divisor resets to 1.
// Each stage holds only while it and every stage after it are full and m_ready is low,
// so bubbles close up under a stall.
module segment_intersection import segint_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  seg_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output seg_out_t              m_data
);

    localparam int NST  = 7 + QW;
    localparam int DIV0 = 6;
    localparam int OUTS = NST - 1;
    localparam int SATW = QW + OUT_WIDTH + 1;
    localparam logic signed [SATW-1:0] OMAX = SATW'((1 << (OUT_WIDTH - 1)) - 1);
    localparam logic signed [SATW-1:0] OMIN = -OMAX - SATW'(1);

    typedef struct packed {
        mode_t                         mode;
        logic signed [COORD_WIDTH-1:0] x0;
        logic signed [COORD_WIDTH-1:0] y0;
        logic signed [DW-1:0]          dxa;
        logic signed [DW-1:0]          dya;
        logic signed [DW-1:0]          dxb;
        logic signed [DW-1:0]          dyb;
        logic signed [DW-1:0]          ex;
        logic signed [DW-1:0]          ey;
        logic signed [DW-1:0]          c0;
        logic signed [DW-1:0]          c1;
    } st1_t;

    typedef struct packed {
        mode_t                         mode;
        logic signed [COORD_WIDTH-1:0] x0;
        logic signed [COORD_WIDTH-1:0] y0;
        logic signed [DW-1:0]          dxa;
        logic signed [DW-1:0]          dya;
        logic signed [DW-1:0]          ex;
        logic signed [DW-1:0]          c0;
        logic signed [DW-1:0]          c1;
        logic signed [PW-1:0]          pa;
        logic signed [PW-1:0]          pb;
        logic signed [PW-1:0]          pc;
        logic signed [PW-1:0]          pd;
    } st2_t;

    typedef struct packed {
        mode_t                         mode;
        logic                          ok;
        logic signed [COORD_WIDTH-1:0] x0;
        logic signed [COORD_WIDTH-1:0] y0;
        logic signed [DW-1:0]          dxa;
        logic signed [DW-1:0]          dya;
        logic signed [DW-1:0]          c0;
        logic signed [DW-1:0]          c1;
        logic signed [EW-1:0]          e;
        logic signed [EW-1:0]          t;
    } st3_t;

    typedef struct packed {
        mode_t                               mode;
        logic                                ok;
        logic                                tin;
        logic signed [EW-1:0]                e;
        logic signed [COORD_WIDTH+EW-1:0]    xe;
        logic signed [COORD_WIDTH+EW-1:0]    ye;
        logic signed [DW+EW-1:0]             c0e;
        logic signed [DW+EW-1:0]             c1e;
        logic signed [DW+EW-1:0]             tdx;
        logic signed [DW+EW-1:0]             tdy;
        logic signed [UDW-1:0]               ud;
    } st4_t;

    typedef struct packed {
        logic                  hit;
        logic signed [NXW-1:0] nx;
        logic signed [NXW-1:0] ny;
        logic signed [UDW-1:0] udx;
        logic signed [UDW-1:0] udy;
    } st5_t;

    typedef struct packed {
        logic           hit;
        logic           sx;
        logic           sy;
        logic [NW-1:0]  numx;
        logic [NW-1:0]  numy;
        logic [DDW-1:0] denx;
        logic [DDW-1:0] deny;
    } st6_t;

    logic [DIV_WIDTH-1:0] div_reg;
    logic [DIV_WIDTH-1:0] div_eff;
    logic [NST-1:0]       v_reg;
    logic [NST-1:0]       adv;
    st1_t                 st1_reg, st1_next;
    st2_t                 st2_reg, st2_next;
    st3_t                 st3_reg, st3_next;
    st4_t                 st4_reg, st4_next;
    st5_t                 st5_reg, st5_next;
    st6_t                 st6_reg, st6_next;
    logic [QW-1:0]        hd_reg, sxd_reg, syd_reg;
    logic [QW-1:0]        qx, qy;
    seg_out_t             out_reg, out_next;

    // config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg <= DIV_WIDTH'(1);
        end else if (psel && penable && pwrite && pready
                     && paddr[ADDR_WIDTH-1] == REG_X_DIVISOR) begin
            div_reg <= pwdata[DIV_WIDTH-1:0];
        end
    end

    assign div_eff = (div_reg == '0) ? DIV_WIDTH'(1) : div_reg;
    assign pready  = 1'b1;
    assign prdata  = (paddr[ADDR_WIDTH-1] == REG_X_DIVISOR) ? 32'(div_reg) : '0;

    // flow control
    always_comb begin
        for (int k = 0; k < NST; k++) begin
            adv[k] = m_ready || !(&(v_reg | ((NST'(1) << k) - NST'(1))));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (adv[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign s_ready = adv[0];
    assign m_valid = v_reg[OUTS];
    assign m_data  = out_reg;

    // stage 1: order, classify, differences
    always_comb begin
        logic                          swa, swb, a_vert, b_vert, skip;
        logic signed [COORD_WIDTH-1:0] oax0, oay0, oax1, oay1;
        logic signed [COORD_WIDTH-1:0] obx0, oby0, obx1, oby1;
        logic signed [COORD_WIDTH-1:0] px0, py0, px1, py1;
        logic signed [COORD_WIDTH-1:0] qx0, qy0, qx1, qy1;
        logic signed [COORD_WIDTH-1:0] cl, cr0, cr1;
        swa    = s_data.ax0 > s_data.ax1;
        swb    = s_data.bx0 > s_data.bx1;
        oax0   = swa ? s_data.ax1 : s_data.ax0;
        oay0   = swa ? s_data.ay1 : s_data.ay0;
        oax1   = swa ? s_data.ax0 : s_data.ax1;
        oay1   = swa ? s_data.ay0 : s_data.ay1;
        obx0   = swb ? s_data.bx1 : s_data.bx0;
        oby0   = swb ? s_data.by1 : s_data.by0;
        obx1   = swb ? s_data.bx0 : s_data.bx1;
        oby1   = swb ? s_data.by0 : s_data.by1;
        a_vert = s_data.ax0 == s_data.ax1;
        b_vert = s_data.bx0 == s_data.bx1;
        skip   = (a_vert && b_vert) || (s_data.ay0 == s_data.ay1 && s_data.by0 == s_data.by1);
        if (skip) begin
            st1_next.mode = MODE_NONE;
        end else if (!a_vert && !b_vert) begin
            st1_next.mode = MODE_SLOPED;
        end else begin
            st1_next.mode = MODE_VERT;
        end
        px0 = oax0;
        py0 = oay0;
        px1 = oax1;
        py1 = oay1;
        qx0 = obx0;
        qy0 = oby0;
        qx1 = obx1;
        qy1 = oby1;
        // vertical: q holds (xv, ymin, xv, ymax), p the sloped segment
        if (st1_next.mode == MODE_VERT) begin
            if (a_vert) begin
                px0 = obx0;
                py0 = oby0;
                px1 = obx1;
                py1 = oby1;
                qx0 = oax0;
                qx1 = oax0;
                qy0 = (oay0 < oay1) ? oay0 : oay1;
                qy1 = (oay0 < oay1) ? oay1 : oay0;
            end else begin
                qx0 = obx0;
                qx1 = obx0;
                qy0 = (oby0 < oby1) ? oby0 : oby1;
                qy1 = (oby0 < oby1) ? oby1 : oby0;
            end
        end
        cl  = (st1_next.mode == MODE_VERT) ? py0 : px0;
        cr0 = (st1_next.mode == MODE_VERT) ? qy0 : qx0;
        cr1 = (st1_next.mode == MODE_VERT) ? qy1 : qx1;
        st1_next.x0  = px0;
        st1_next.y0  = py0;
        st1_next.dxa = DW'(px1) - DW'(px0);
        st1_next.dya = DW'(py1) - DW'(py0);
        st1_next.dxb = DW'(qx1) - DW'(qx0);
        st1_next.dyb = DW'(qy1) - DW'(qy0);
        st1_next.ex  = DW'(qx0) - DW'(px0);
        st1_next.ey  = DW'(qy0) - DW'(py0);
        st1_next.c0  = DW'(cl) - DW'(cr0);
        st1_next.c1  = DW'(cl) - DW'(cr1);
    end

    // stage 2: cross products
    always_comb begin
        st2_next.mode = st1_reg.mode;
        st2_next.x0   = st1_reg.x0;
        st2_next.y0   = st1_reg.y0;
        st2_next.dxa  = st1_reg.dxa;
        st2_next.dya  = st1_reg.dya;
        st2_next.ex   = st1_reg.ex;
        st2_next.c0   = st1_reg.c0;
        st2_next.c1   = st1_reg.c1;
        st2_next.pa   = st1_reg.dxa * st1_reg.dyb;
        st2_next.pb   = st1_reg.dya * st1_reg.dxb;
        st2_next.pc   = st1_reg.ex * st1_reg.dyb;
        st2_next.pd   = st1_reg.ey * st1_reg.dxb;
    end

    // stage 3: denominator e >= 0 and parameter t
    always_comb begin
        logic signed [EW-1:0] ev, tv;
        ev = EW'(st2_reg.pa) - EW'(st2_reg.pb);
        tv = EW'(st2_reg.pc) - EW'(st2_reg.pd);
        if (st2_reg.mode == MODE_VERT) begin
            ev = EW'(st2_reg.dxa);
            tv = EW'(st2_reg.ex);
        end
        if (ev[EW-1]) begin
            ev = -ev;
            tv = -tv;
        end
        st3_next.mode = st2_reg.mode;
        st3_next.ok   = (st2_reg.mode != MODE_NONE) && (ev != '0);
        st3_next.x0   = st2_reg.x0;
        st3_next.y0   = st2_reg.y0;
        st3_next.dxa  = st2_reg.dxa;
        st3_next.dya  = st2_reg.dya;
        st3_next.c0   = st2_reg.c0;
        st3_next.c1   = st2_reg.c1;
        st3_next.e    = ev;
        st3_next.t    = tv;
    end

    // stage 4: scaled terms
    always_comb begin
        st4_next.mode = st3_reg.mode;
        st4_next.ok   = st3_reg.ok;
        st4_next.tin  = !st3_reg.t[EW-1] && (st3_reg.t <= st3_reg.e);
        st4_next.e    = st3_reg.e;
        st4_next.xe   = st3_reg.x0 * st3_reg.e;
        st4_next.ye   = st3_reg.y0 * st3_reg.e;
        st4_next.c0e  = st3_reg.c0 * st3_reg.e;
        st4_next.c1e  = st3_reg.c1 * st3_reg.e;
        st4_next.tdx  = st3_reg.t * st3_reg.dxa;
        st4_next.tdy  = st3_reg.t * st3_reg.dya;
        st4_next.ud   = st3_reg.e * $signed({1'b0, div_eff});
    end

    // stage 5: numerators and range tests
    always_comb begin
        logic signed [DW+EW-1:0] tm;
        logic signed [NXW-1:0]   g0, g1;
        tm = (st4_reg.mode == MODE_VERT) ? st4_reg.tdy : st4_reg.tdx;
        g0 = NXW'(st4_reg.c0e) + NXW'(tm);
        g1 = NXW'(st4_reg.c1e) + NXW'(tm);
        st5_next.hit = st4_reg.ok && st4_reg.tin && !g0[NXW-1] && (g1[NXW-1] || g1 == '0);
        st5_next.nx  = NXW'(st4_reg.xe) + NXW'(st4_reg.tdx);
        st5_next.ny  = NXW'(st4_reg.ye) + NXW'(st4_reg.tdy);
        st5_next.udx = st4_reg.ud;
        st5_next.udy = UDW'(st4_reg.e);
    end

    // stage 6: round-half-away operands (2*16*|n| + d) / (2*d)
    always_comb begin
        logic [NXW-1:0] magx, magy;
        magx = st5_reg.nx[NXW-1] ? NXW'(-st5_reg.nx) : NXW'(st5_reg.nx);
        magy = st5_reg.ny[NXW-1] ? NXW'(-st5_reg.ny) : NXW'(st5_reg.ny);
        st6_next.hit  = st5_reg.hit;
        st6_next.sx   = st5_reg.nx[NXW-1];
        st6_next.sy   = st5_reg.ny[NXW-1];
        st6_next.numx = (NW'(magx) << 5) + NW'($unsigned(st5_reg.udx));
        st6_next.numy = (NW'(magy) << 5) + NW'($unsigned(st5_reg.udy));
        st6_next.denx = {$unsigned(st5_reg.udx), 1'b0};
        st6_next.deny = {$unsigned(st5_reg.udy), 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            st1_reg <= st1_next;
        end
        if (adv[1]) begin
            st2_reg <= st2_next;
        end
        if (adv[2]) begin
            st3_reg <= st3_next;
        end
        if (adv[3]) begin
            st4_reg <= st4_next;
        end
        if (adv[4]) begin
            st5_reg <= st5_next;
        end
        if (adv[5]) begin
            st6_reg <= st6_next;
        end
    end

    segint_rdiv u_div_x (
        .aclk (aclk),
        .adv  (adv[DIV0 +: QW]),
        .num  (st6_reg.numx),
        .den  (st6_reg.denx),
        .quo  (qx)
    );

    segint_rdiv u_div_y (
        .aclk (aclk),
        .adv  (adv[DIV0 +: QW]),
        .num  (st6_reg.numy),
        .den  (st6_reg.deny),
        .quo  (qy)
    );

    // side bits alongside the divider stages
    always_ff @(posedge aclk) begin
        if (adv[DIV0]) begin
            hd_reg[0]  <= st6_reg.hit;
            sxd_reg[0] <= st6_reg.sx;
            syd_reg[0] <= st6_reg.sy;
        end
        for (int j = 1; j < QW; j++) begin
            if (adv[DIV0 + j]) begin
                hd_reg[j]  <= hd_reg[j-1];
                sxd_reg[j] <= sxd_reg[j-1];
                syd_reg[j] <= syd_reg[j-1];
            end
        end
    end

    // output: sign, saturate, zero on miss
    always_comb begin
        logic signed [SATW-1:0] vx, vy;
        vx = sxd_reg[QW-1] ? -SATW'({1'b0, qx}) : SATW'({1'b0, qx});
        vy = syd_reg[QW-1] ? -SATW'({1'b0, qy}) : SATW'({1'b0, qy});
        if (vx > OMAX) begin
            vx = OMAX;
        end else if (vx < OMIN) begin
            vx = OMIN;
        end
        if (vy > OMAX) begin
            vy = OMAX;
        end else if (vy < OMIN) begin
            vy = OMIN;
        end
        out_next.hit     = hd_reg[QW-1];
        out_next.cross_x = hd_reg[QW-1] ? OUT_WIDTH'(vx) : '0;
        out_next.cross_y = hd_reg[QW-1] ? OUT_WIDTH'(vy) : '0;
    end

    always_ff @(posedge aclk) begin
        if (adv[OUTS]) begin
            out_reg <= out_next;
        end
    end

endmodule

@@ sim/tb_segment_intersection.sv @@
module tb_segment_intersection;
    import segint_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 7 + QW;
    localparam int STALL_MAX = 400;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_WIDTH-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    seg_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    seg_out_t              m_data;

    segment_intersection uut (.*);

    seg_out_t   expected_q[$];
    logic [7:0] divisor;
    int         mismatches;
    int         idle_cycles;
    bit         send_gaps;
    bit         recv_gaps;
    bit         hold_off;
    bit         timed_out;

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint q_div(longint n, longint d);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q   = (2 * mag + d) / (2 * d);
        return (n < 0) ? -q : q;
    endfunction

    function automatic logic signed [OUT_WIDTH-1:0] clamp24(longint v);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[OUT_WIDTH-1:0];
    endfunction

    function automatic bit vertical_cross(longint xv, longint v0, longint v1,
                                          longint sx0, longint sy0, longint sx1,
                                          longint sy1, longint dv,
                                          output longint ox, output longint oy);
        longint dx;
        longint yn;
        longint lo;
        longint hi;
        ox = 0;
        oy = 0;
        dx = sx1 - sx0;
        if (xv < sx0 || xv > sx1) return 0;
        yn = sy0 * dx + (sy1 - sy0) * (xv - sx0);
        lo = (v0 < v1) ? v0 : v1;
        hi = (v0 < v1) ? v1 : v0;
        if (yn < lo * dx || yn > hi * dx) return 0;
        lo = (sy0 < sy1) ? sy0 : sy1;
        hi = (sy0 < sy1) ? sy1 : sy0;
        if (yn < lo * dx || yn > hi * dx) return 0;
        ox = q_div(16 * xv, dv);
        oy = q_div(16 * yn, dx);
        return 1;
    endfunction

    function automatic seg_out_t predict_crossing(seg_in_t s);
        longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, t, dv, ox, oy;
        longint dxa, dya, dxb, dyb, e, tn, xe;
        bit hit;
        seg_out_t r;
        ax0 = s.ax0; ay0 = s.ay0; ax1 = s.ax1; ay1 = s.ay1;
        bx0 = s.bx0; by0 = s.by0; bx1 = s.bx1; by1 = s.by1;
        dv  = (divisor == 0) ? 1 : divisor;
        ox  = 0;
        oy  = 0;
        hit = 0;
        if (!((ax0 == ax1 && bx0 == bx1) || (ay0 == ay1 && by0 == by1))) begin
            if (ax0 > ax1) begin
                t = ax0; ax0 = ax1; ax1 = t;
                t = ay0; ay0 = ay1; ay1 = t;
            end
            if (bx0 > bx1) begin
                t = bx0; bx0 = bx1; bx1 = t;
                t = by0; by0 = by1; by1 = t;
            end
            if (ax0 != ax1 && bx0 != bx1) begin
                dxa = ax1 - ax0; dya = ay1 - ay0;
                dxb = bx1 - bx0; dyb = by1 - by0;
                e   = dxa * dyb - dya * dxb;
                tn  = (bx0 - ax0) * dyb - (by0 - ay0) * dxb;
                if (e != 0) begin
                    if (e < 0) begin
                        e  = -e;
                        tn = -tn;
                    end
                    xe = (ax0 - bx0) * e + tn * dxa;
                    if (tn >= 0 && tn <= e && xe >= 0 && xe <= dxb * e) begin
                        ox  = q_div(16 * (ax0 * e + tn * dxa), e * dv);
                        oy  = q_div(16 * (ay0 * e + tn * dya), e);
                        hit = 1;
                    end
                end
            end else if (ax0 == ax1) begin
                hit = vertical_cross(ax0, ay0, ay1, bx0, by0, bx1, by1, dv, ox, oy);
            end else begin
                hit = vertical_cross(bx0, by0, by1, ax0, ay0, ax1, ay1, dv, ox, oy);
            end
        end
        if (!hit) begin
            ox = 0;
            oy = 0;
        end
        r.hit     = hit;
        r.cross_x = clamp24(ox);
        r.cross_y = clamp24(oy);
        return r;
    endfunction

    // receiver with random stalls and an optional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !hold_off && !(recv_gaps && $urandom_range(99) < 13);
        end
    end

    always @(posedge aclk) begin
        seg_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %h", m_data);
            end else begin
                want = expected_q.pop_front();
                if (m_data.hit !== want.hit || m_data.cross_x !== want.cross_x ||
                    m_data.cross_y !== want.cross_y) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp hit=%0b x=%0d y=%0d got hit=%0b x=%0d y=%0d",
                                 want.hit, want.cross_x, want.cross_y,
                                 m_data.hit, m_data.cross_x, m_data.cross_y);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000 && !timed_out) begin
                timed_out = 1;
                $display("segment_intersection verification failed");
                $finish;
            end
        end
    end

    task automatic send_segments(seg_in_t s);
        while (send_gaps && $urandom_range(99) < 13) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= s;
        do @(posedge aclk); while (!s_ready);
        expected_q.push_back(predict_crossing(s));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_divisor(logic [7:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WIDTH'(REG_X_DIVISOR) << 2;
        pwdata  <= {24'h0, v};
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        divisor  = v;
    endtask

    function automatic seg_in_t make_seg(int a, int b, int c, int d,
                                         int e, int f, int g, int h);
        seg_in_t s;
        s.ax0 = COORD_WIDTH'(a); s.ay0 = COORD_WIDTH'(b);
        s.ax1 = COORD_WIDTH'(c); s.ay1 = COORD_WIDTH'(d);
        s.bx0 = COORD_WIDTH'(e); s.by0 = COORD_WIDTH'(f);
        s.bx1 = COORD_WIDTH'(g); s.by1 = COORD_WIDTH'(h);
        return s;
    endfunction

    function automatic seg_in_t random_seg();
        seg_in_t s;
        int k;
        s = seg_in_t'({$urandom, $urandom, $urandom, $urandom});
        k = $urandom_range(9);
        if (k < 6) begin
            // crossing-prone: small coordinates around origin
            s.ax0 = COORD_WIDTH'($signed($urandom_range(2000)) - 1000);
            s.ay0 = COORD_WIDTH'($signed($urandom_range(2000)) - 1000);
            s.ax1 = COORD_WIDTH'(-s.ax0 + $signed($urandom_range(60)) - 30);
            s.ay1 = COORD_WIDTH'(-s.ay0 + $signed($urandom_range(60)) - 30);
            s.bx0 = COORD_WIDTH'($signed($urandom_range(2000)) - 1000);
            s.by0 = COORD_WIDTH'($signed($urandom_range(2000)) - 1000);
            s.bx1 = COORD_WIDTH'(-s.bx0 + $signed($urandom_range(60)) - 30);
            s.by1 = COORD_WIDTH'(-s.by0 + $signed($urandom_range(60)) - 30);
        end else if (k == 6) begin
            s.ax1 = s.ax0;
        end else if (k == 7) begin
            s.bx1 = s.bx0;
            s.ax0 = COORD_WIDTH'(s.bx0 - $signed($urandom_range(100)));
            s.ax1 = COORD_WIDTH'(s.bx0 + $signed($urandom_range(100)));
        end
        return s;
    endfunction

    task automatic test_directed();
        send_segments(make_seg(-160, -160, 160, 160, -160, 160, 160, -160));
        send_segments(make_seg(0, 0, 16, 0, 0, 16, 16, 16));
        send_segments(make_seg(0, 0, 0, 16, 16, 0, 16, 16));
        send_segments(make_seg(0, -16, 0, 16, -16, 0, 16, 0));
        send_segments(make_seg(16, 0, -16, 0, 0, 16, 0, -16));
        send_segments(make_seg(0, 0, 32, 32, 16, 16, 48, 48));
        send_segments(make_seg(0, 0, 32, 32, 0, 16, 32, 48));
        send_segments(make_seg(5, 5, 5, 5, 0, 0, 10, 10));
        send_segments(make_seg(5, 5, 5, 5, 5, 5, 5, 5));
        send_segments(make_seg(0, 0, 10, 10, 10, 10, 20, 0));
        send_segments(make_seg(0, 0, 10, 10, 11, 11, 20, 0));
        send_segments(make_seg(-32768, -32768, 32767, 32767,
                               -32768, 32767, 32767, -32768));
        send_segments(make_seg(32767, -32768, 32767, 32767,
                               -32768, 32767, 32767, 32767));
        send_segments(make_seg(-32768, 32767, -32768, -32768,
                               -32768, 0, 32767, 1));
        send_segments(make_seg(0, 0, 3, 1, 0, 1, 3, 0));
        send_segments(make_seg(-1, -1, 1, 1, -1, 1, 1, -1));
        send_segments(make_seg(-1, 0, 2, 1, 1, -1, 0, 3));
    endtask

    task automatic test_random(int count);
        repeat (count) send_segments(random_seg());
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1;
                repeat (200) @(posedge aclk);
                hold_off = 0;
            end
            test_random(80);
        join
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        s_valid = 0; s_data = '0;
        divisor = 1; mismatches = 0; timed_out = 0;
        send_gaps = 1; recv_gaps = 1; hold_off = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        drain();
        write_divisor(8'd255);
        test_directed();
        test_random(100);
        drain();
        write_divisor(8'd3);
        send_gaps = 0; recv_gaps = 0;
        test_random(100);
        send_gaps = 1; recv_gaps = 1;
        test_backpressure();
        write_divisor(8'd0);
        test_random(60);
        drain();
        write_divisor(8'd1);
        test_random(100);
        drain();
        write_divisor(8'($urandom_range(2, 254)));
        test_random(60);
        drain();

        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("segment_intersection verification clean");
        end else begin
            $display("segment_intersection verification failed");
        end
        $finish;
    end
endmodule
